>>> rtl/tssg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssg_pkg
// Shared types and constants of the triangle scanline span generator.
// ----------------------------------------------------------------------------
package tssg_pkg;

  localparam int ROW_W      = 6;
  localparam int COLOR_W    = 32;
  localparam int HEIGHT_W   = 7;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT   = 1'b0;
  localparam logic [HEIGHT_W-1:0]  SCREEN_HEIGHT_RESET = 7'd64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SORT0,
    S_SORT1,
    S_SORT2,
    S_SETUP,
    S_LONG,
    S_LONG_WAIT,
    S_SHORT,
    S_SHORT_WAIT,
    S_EMIT
  } seq_state_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_MUL,
    E_ABS,
    E_DIV,
    E_FIN
  } edge_state_t;

endpackage

>>> rtl/tssg_tri_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssg_tri_if
// Triangle channel: three signed vertices and a fill color per word.
// ----------------------------------------------------------------------------
interface tssg_tri_if import tssg_pkg::*; #(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_a_x;
  logic signed [COORD_WIDTH-1:0] vertex_a_y;
  logic signed [COORD_WIDTH-1:0] vertex_b_x;
  logic signed [COORD_WIDTH-1:0] vertex_b_y;
  logic signed [COORD_WIDTH-1:0] vertex_c_x;
  logic signed [COORD_WIDTH-1:0] vertex_c_y;
  logic [COLOR_W-1:0]            fill_color;

  modport source (
    output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
           vertex_c_x, vertex_c_y, fill_color,
    input  ready
  );

  modport sink (
    input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
           vertex_c_x, vertex_c_y, fill_color,
    output ready
  );
endinterface

>>> rtl/tssg_span_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssg_span_if
// Span channel: one horizontal span of a triangle per word.
// ----------------------------------------------------------------------------
interface tssg_span_if import tssg_pkg::*; #(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] span_left;
  logic signed [COORD_WIDTH-1:0] span_right;
  logic [ROW_W-1:0]              span_row;
  logic [COLOR_W-1:0]            span_color;
  logic                          last_span;

  modport source (
    output valid, span_left, span_right, span_row, span_color, last_span,
    input  ready
  );

  modport sink (
    input  valid, span_left, span_right, span_row, span_color, last_span,
    output ready
  );
endinterface

>>> rtl/tssg_edge_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssg_edge_unit
// Shared edge interpolator: xs + (xe-xs)*(row-ys)/(ye-ys), one multiply then
// a bit-serial restoring divide, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module tssg_edge_unit import tssg_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [COORD_WIDTH-1:0] xs,
  input  logic signed [COORD_WIDTH-1:0] ys,
  input  logic signed [COORD_WIDTH-1:0] xe,
  input  logic signed [COORD_WIDTH-1:0] ye,
  input  logic [ROW_W-1:0]              row,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] x
);
  localparam int CW    = COORD_WIDTH;
  localparam int CNT_W = $clog2(CW);
  localparam int PW    = 2 * CW + 2;

  edge_state_t state, state_next;

  logic signed [CW:0]   dx;
  logic [CW-1:0]        t;
  logic [CW-1:0]        dy;
  logic signed [CW-1:0] xs_r;
  logic signed [PW-1:0] prod;
  logic                 neg;
  logic [CW-1:0]        rem;
  logic [CW-1:0]        quo;
  logic [CNT_W-1:0]     cnt;

  logic signed [CW:0]   t_full;
  logic signed [CW:0]   dy_full;
  logic [PW-1:0]        mag;
  logic [CW:0]          trial;
  logic [CW:0]          diff;
  logic                 ge;
  logic signed [CW:0]   qs;
  logic signed [CW:0]   xsum;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      E_IDLE:  if (start) state_next = E_MUL;
      E_MUL:   state_next = E_ABS;
      E_ABS:   state_next = E_DIV;
      E_DIV:   if (cnt == '0) state_next = E_FIN;
      E_FIN:   state_next = E_IDLE;
      default: state_next = E_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done = (state == E_FIN);
    qs   = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    xsum = $signed({xs_r[CW-1], xs_r}) + qs;
    x    = xsum[CW-1:0];
  end

  // datapath helpers
  always_comb begin
    t_full  = $signed({{(CW+1-ROW_W){1'b0}}, row}) - $signed({ys[CW-1], ys});
    dy_full = $signed({ye[CW-1], ye}) - $signed({ys[CW-1], ys});
    mag     = prod[PW-1] ? PW'(-prod) : PW'(prod);
    trial   = {rem, quo[CW-1]};
    diff    = trial - {1'b0, dy};
    ge      = (trial >= {1'b0, dy});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      E_IDLE: begin
        if (start) begin
          dx   <= $signed({xe[CW-1], xe}) - $signed({xs[CW-1], xs});
          t    <= t_full[CW-1:0];
          dy   <= dy_full[CW-1:0];
          xs_r <= xs;
        end
      end
      E_MUL: begin
        prod <= dx * $signed({1'b0, t});
      end
      E_ABS: begin
        neg <= prod[PW-1];
        rem <= mag[2*CW-1:CW];
        quo <= mag[CW-1:0];
        cnt <= CNT_W'(CW - 1);
      end
      E_DIV: begin
        rem <= ge ? diff[CW-1:0] : trial[CW-1:0];
        quo <= {quo[CW-2:0], ge};
        cnt <= cnt - 1'b1;
      end
      E_FIN: begin
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/tssg_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssg_seq
// Triangle sequencer: vertex sort, row clipping, row loop driving the shared
// edge unit, and the span output register.
// ----------------------------------------------------------------------------
module tssg_seq import tssg_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int MAX_ROWS    = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [HEIGHT_W-1:0] screen_height,
  tssg_tri_if.sink            tri_in,
  tssg_span_if.source         span_out
);
  localparam int CW = COORD_WIDTH;
  localparam logic [HEIGHT_W-1:0] MAX_ROWS_H = HEIGHT_W'(MAX_ROWS);

  seq_state_t state, state_next;

  logic signed [CW-1:0] vx0, vx1, vx2;
  logic signed [CW-1:0] vy0, vy1, vy2;
  logic [COLOR_W-1:0]   color;
  logic [ROW_W-1:0]     row;
  logic [ROW_W-1:0]     yend;
  logic signed [CW-1:0] xa;
  logic signed [CW-1:0] xb;

  logic                 out_valid;
  logic signed [CW-1:0] out_left;
  logic signed [CW-1:0] out_right;
  logic [ROW_W-1:0]     out_row;
  logic [COLOR_W-1:0]   out_color;
  logic                 out_last;

  logic signed [CW-1:0] cmp_ay, cmp_by;
  logic                 swap_en;
  logic [HEIGHT_W-1:0]  rows_c;
  logic [HEIGHT_W-1:0]  rows_m1;
  logic signed [CW:0]   rows_s;
  logic signed [CW:0]   y0_s;
  logic signed [CW:0]   y2_s;
  logic                 empty;
  logic [ROW_W-1:0]     ystart_c;
  logic [ROW_W-1:0]     yend_c;
  logic signed [CW:0]   row_s;
  logic                 upper;
  logic                 short_flat;
  logic signed [CW-1:0] flat_x;
  logic                 out_free;
  logic                 last_row;

  logic                 eu_start;
  logic                 eu_done;
  logic signed [CW-1:0] eu_xs, eu_ys, eu_xe, eu_ye, eu_x;

  // one compare-swap stage shared by the sort network
  always_comb begin
    cmp_ay  = (state == S_SORT1) ? vy1 : vy0;
    cmp_by  = (state == S_SORT1) ? vy2 : vy1;
    swap_en = (cmp_ay > cmp_by);
  end

  // row clipping
  always_comb begin
    rows_c   = (screen_height > MAX_ROWS_H) ? MAX_ROWS_H : screen_height;
    rows_m1  = rows_c - 1'b1;
    rows_s   = $signed({{(CW+1-HEIGHT_W){1'b0}}, rows_c});
    y0_s     = $signed({vy0[CW-1], vy0});
    y2_s     = $signed({vy2[CW-1], vy2});
    empty    = (vy0 == vy2) || (rows_c == '0) || (y0_s >= rows_s) || vy2[CW-1];
    ystart_c = vy0[CW-1] ? '0 : vy0[ROW_W-1:0];
    yend_c   = (y2_s >= rows_s) ? rows_m1[ROW_W-1:0] : vy2[ROW_W-1:0];
  end

  // short edge selection
  always_comb begin
    row_s      = $signed({{(CW+1-ROW_W){1'b0}}, row});
    upper      = (row_s < $signed({vy1[CW-1], vy1}));
    short_flat = upper ? (vy1 == vy0) : (vy2 == vy1);
    flat_x     = upper ? vx1 : vx2;
    if (state == S_LONG || state == S_LONG_WAIT) begin
      eu_xs = vx0; eu_ys = vy0; eu_xe = vx2; eu_ye = vy2;
    end else if (upper) begin
      eu_xs = vx0; eu_ys = vy0; eu_xe = vx1; eu_ye = vy1;
    end else begin
      eu_xs = vx1; eu_ys = vy1; eu_xe = vx2; eu_ye = vy2;
    end
  end

  assign out_free = !out_valid || span_out.ready;
  assign last_row = (row == yend);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (tri_in.valid) state_next = S_SORT0;
      S_SORT0:      state_next = S_SORT1;
      S_SORT1:      state_next = S_SORT2;
      S_SORT2:      state_next = S_SETUP;
      S_SETUP:      state_next = empty ? S_IDLE : S_LONG;
      S_LONG:       state_next = S_LONG_WAIT;
      S_LONG_WAIT:  if (eu_done) state_next = S_SHORT;
      S_SHORT:      state_next = short_flat ? S_EMIT : S_SHORT_WAIT;
      S_SHORT_WAIT: if (eu_done) state_next = S_EMIT;
      S_EMIT:       if (out_free) state_next = last_row ? S_IDLE : S_LONG;
      default:      state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    tri_in.ready = (state == S_IDLE);
    eu_start     = (state == S_LONG) || (state == S_SHORT && !short_flat);
  end

  assign span_out.valid      = out_valid;
  assign span_out.span_left  = out_left;
  assign span_out.span_right = out_right;
  assign span_out.span_row   = out_row;
  assign span_out.span_color = out_color;
  assign span_out.last_span  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (span_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (tri_in.valid) begin
          vx0   <= tri_in.vertex_a_x;
          vy0   <= tri_in.vertex_a_y;
          vx1   <= tri_in.vertex_b_x;
          vy1   <= tri_in.vertex_b_y;
          vx2   <= tri_in.vertex_c_x;
          vy2   <= tri_in.vertex_c_y;
          color <= tri_in.fill_color;
        end
      end
      S_SORT0, S_SORT2: begin
        if (swap_en) begin
          vx0 <= vx1; vy0 <= vy1;
          vx1 <= vx0; vy1 <= vy0;
        end
      end
      S_SORT1: begin
        if (swap_en) begin
          vx1 <= vx2; vy1 <= vy2;
          vx2 <= vx1; vy2 <= vy1;
        end
      end
      S_SETUP: begin
        row  <= ystart_c;
        yend <= yend_c;
      end
      S_LONG_WAIT: begin
        if (eu_done) xa <= eu_x;
      end
      S_SHORT: begin
        if (short_flat) xb <= flat_x;
      end
      S_SHORT_WAIT: begin
        if (eu_done) xb <= eu_x;
      end
      S_EMIT: begin
        if (out_free) begin
          out_left  <= (xa > xb) ? xb : xa;
          out_right <= (xa > xb) ? xa : xb;
          out_row   <= row;
          out_color <= color;
          out_last  <= last_row;
          row       <= row + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  tssg_edge_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_edge (
    .clk   (clk),
    .rst   (rst),
    .start (eu_start),
    .xs    (eu_xs),
    .ys    (eu_ys),
    .xe    (eu_xe),
    .ye    (eu_ye),
    .row   (row),
    .done  (eu_done),
    .x     (eu_x)
  );

endmodule

>>> rtl/triangle_scanline_span_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_scanline_span_generator
// Scanline triangle fill: emits one horizontal span per visible row.
//
// tri_in takes one triangle word (three signed vertices, fill color); span_out
// gives one span word per row from the clipped top row down, last_span set on
// the final one. Flat or vertically off-screen triangles give no spans. The APB
// port holds screen_height at byte address 0; pready is always high.
// A triangle passes through sort and setup, then for each row the single edge
// unit runs one multiply and a one-bit-per-cycle divide for each of the two
// row ends in turn; the short end needs no divide when its edge is flat.
// tri_in.ready is high only between triangles; the next triangle is taken
// while the last span still waits in the output register. A stalled
// span_out holds its word and the row loop waits on it. Reset empties the
// output register, returns to idle and sets screen_height to 64.
// ----------------------------------------------------------------------------
module triangle_scanline_span_generator import tssg_pkg::*; #(
  parameter int MAX_ROWS    = 64,
  parameter int COORD_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  tssg_tri_if.sink              tri_in,
  tssg_span_if.source           span_out
);

  logic [HEIGHT_W-1:0]  screen_height;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_SCREEN_HEIGHT) begin
      prdata = {{(APB_DATA_W-HEIGHT_W){1'b0}}, screen_height};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (wr_en && reg_idx == REG_SCREEN_HEIGHT) begin
      screen_height <= pwdata[HEIGHT_W-1:0];
    end
  end

  tssg_seq #(
    .COORD_WIDTH (COORD_WIDTH),
    .MAX_ROWS    (MAX_ROWS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .screen_height (screen_height),
    .tri_in        (tri_in),
    .span_out      (span_out)
  );

endmodule

>>> rtl/tssg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssg_checker
// Port-level checks of the span generator, bound to the top level.
// ----------------------------------------------------------------------------
module tssg_checker import tssg_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          span_valid,
  input logic                          span_ready,
  input logic signed [COORD_WIDTH-1:0] span_left,
  input logic signed [COORD_WIDTH-1:0] span_right,
  input logic [ROW_W-1:0]              span_row,
  input logic [COLOR_W-1:0]            span_color,
  input logic                          last_span
);

  // one triangle at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a triangle is in progress");

  // a non-final span means the row loop is still running
  a_busy_mid_triangle: assert property (@(posedge clk) disable iff (rst)
    span_valid && !last_span |-> !in_ready)
    else $error("ready for a triangle before its last span");

  a_span_ordered: assert property (@(posedge clk) disable iff (rst)
    span_valid |-> span_left <= span_right)
    else $error("span left end past right end");

  a_span_hold: assert property (@(posedge clk) disable iff (rst)
    span_valid && !span_ready |=> span_valid && $stable(span_left) &&
      $stable(span_right) && $stable(span_row) && $stable(span_color) &&
      $stable(last_span))
    else $error("stalled span word changed");

endmodule

bind triangle_scanline_span_generator tssg_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_tssg_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (tri_in.valid),
  .in_ready   (tri_in.ready),
  .span_valid (span_out.valid),
  .span_ready (span_out.ready),
  .span_left  (span_out.span_left),
  .span_right (span_out.span_right),
  .span_row   (span_out.span_row),
  .span_color (span_out.span_color),
  .last_span  (span_out.last_span)
);
